>>> design/hsa2d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsa2d_pkg
// shared types, widths and the saturating q16.16 add of the 2d histogram
// ----------------------------------------------------------------------------
package hsa2d_pkg;

   localparam int ROW_W              = 9;
   localparam int COL_W              = 9;
   localparam int VALUE_W            = 32;
   localparam int STRIDE_W           = 10;
   localparam int ADDR_OUT_W         = 18;
   localparam int FULL_ADDR_W        = ROW_W + STRIDE_W + 1;
   localparam int DEFAULT_BIN_COUNT  = 512;
   localparam int DEFAULT_INDEX_BITS = 9;

   typedef struct packed {
      logic [ROW_W-1:0]          row_index;
      logic [COL_W-1:0]          col_index;
      logic signed [VALUE_W-1:0] add_value;
      logic                      last_item;
   } req_word_type;

   typedef struct packed {
      logic [ADDR_OUT_W-1:0]     bin_address;
      logic signed [VALUE_W-1:0] bin_total;
      logic                      out_of_range;
      logic                      saturated;
      logic                      last_result;
   } rsp_word_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] total;
      logic                      saturated;
   } sat_sum_type;

   function automatic sat_sum_type sat_add(input logic signed [VALUE_W-1:0] a,
                                           input logic signed [VALUE_W-1:0] b);
      logic signed [VALUE_W:0] sum;
      sat_sum_type             res;
      sum = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
      if (sum[VALUE_W] != sum[VALUE_W-1]) begin
         res.saturated = 1'b1;
         res.total     = sum[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                      : {1'b0, {(VALUE_W-1){1'b1}}};
      end else begin
         res.saturated = 1'b0;
         res.total     = sum[VALUE_W-1:0];
      end
      return res;
   endfunction

endpackage
`default_nettype wire

>>> design/hsa2d_bin_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsa2d_bin_store
// simple dual port bin memory (one write port, one read port) with registered read data
// ----------------------------------------------------------------------------
module hsa2d_bin_store #(
   parameter int BIN_COUNT = 512,
   parameter int ADDR_W    = 9,
   parameter int DATA_W    = 32
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [BIN_COUNT];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> design/histogram_scatter_add_2d_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// histogram_scatter_add_2d_unit
// 2d scatter-add histogram: bin = row * row_stride + col, saturating add
// ----------------------------------------------------------------------------
// usage
//   a word on req_data is taken at a clock edge with start high and busy low.
//   one result word per item appears on rsp_data with rsp_valid high for
//   exactly one cycle, registered after the read and modify states; the
//   receiver cannot hold it off.
//   an item passes address multiply, bin memory read (registered read
//   data), then add, saturate and write back. busy is high in the read and
//   modify states after each accepted word, so a new word is taken only once
//   the previous item is through, in the same cycle as its result is shown.
//   after reset the bin memory is swept to zero, one bin per cycle, which
//   keeps busy high until the last bin is cleared; row_stride resets to zero.
//   row_stride is written through csr_we / csr_wdata at any time, but
//   changes only while the block is idle give defined results.
//   an address at or beyond BIN_COUNT is flagged out_of_range, returns a
//   zero total and leaves the memory untouched.
// ----------------------------------------------------------------------------
module histogram_scatter_add_2d_unit #(
   parameter int BIN_COUNT  = hsa2d_pkg::DEFAULT_BIN_COUNT,
   parameter int INDEX_BITS = hsa2d_pkg::DEFAULT_INDEX_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire hsa2d_pkg::req_word_type            req_data,
   output logic                                    rsp_valid,
   output hsa2d_pkg::rsp_word_type                 rsp_data,
   input  wire logic                               csr_we,
   input  wire logic [hsa2d_pkg::STRIDE_W-1:0]     csr_wdata
);
   import hsa2d_pkg::*;

   localparam int ADDR_W = $clog2(BIN_COUNT);

   localparam logic [ROW_W-1:0] ROW_MASK = (INDEX_BITS >= ROW_W) ? {ROW_W{1'b1}}
                                         : ROW_W'((1 << INDEX_BITS) - 1);
   localparam logic [COL_W-1:0] COL_MASK = (INDEX_BITS >= COL_W) ? {COL_W{1'b1}}
                                         : COL_W'((1 << INDEX_BITS) - 1);
   localparam logic [FULL_ADDR_W-1:0] BIN_LIMIT = FULL_ADDR_W'(BIN_COUNT);
   localparam logic [ADDR_W-1:0]      LAST_BIN  = ADDR_W'(BIN_COUNT - 1);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_READ   = 2'd2;
   localparam logic [1:0] ST_MODIFY = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [STRIDE_W-1:0]         stride_ff;
   logic [ADDR_W-1:0]           clr_addr_ff;
   logic [ADDR_W-1:0]           addr_ff;
   logic [ADDR_OUT_W-1:0]       addr_out_ff;
   logic                        oor_ff;
   logic signed [VALUE_W-1:0]   value_ff;
   logic                        last_ff;
   logic                        rsp_valid_ff;
   rsp_word_type                rsp_ff;

   logic                        accept;
   logic [ROW_W-1:0]            row_m;
   logic [COL_W-1:0]            col_m;
   logic [ROW_W+STRIDE_W-1:0]   product;
   logic [FULL_ADDR_W-1:0]      full_addr;
   logic [VALUE_W-1:0]          rd_data;
   sat_sum_type                 sum;
   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr;
   logic [VALUE_W-1:0]          wr_data;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign row_m     = req_data.row_index & ROW_MASK;
   assign col_m     = req_data.col_index & COL_MASK;
   assign product   = {{STRIDE_W{1'b0}}, row_m} * {{ROW_W{1'b0}}, stride_ff};
   assign full_addr = {1'b0, product} + {{(FULL_ADDR_W-COL_W){1'b0}}, col_m};
   assign sum       = sat_add(signed'(rd_data), value_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == LAST_BIN) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_READ;
         end
         ST_READ:   state_in = ST_MODIFY;
         ST_MODIFY: state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = (state_ff == ST_MODIFY) && !oor_ff;
         wr_addr = addr_ff;
         wr_data = sum.total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         stride_ff    <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_MODIFY);
         if (csr_we) begin
            stride_ff <= csr_wdata;
         end
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff     <= full_addr[ADDR_W-1:0];
         addr_out_ff <= full_addr[ADDR_OUT_W-1:0];
         oor_ff      <= (full_addr >= BIN_LIMIT);
         value_ff    <= req_data.add_value;
         last_ff     <= req_data.last_item;
      end
      if (state_ff == ST_MODIFY) begin
         rsp_ff.bin_address  <= addr_out_ff;
         rsp_ff.bin_total    <= oor_ff ? '0 : sum.total;
         rsp_ff.out_of_range <= oor_ff;
         rsp_ff.saturated    <= oor_ff ? 1'b0 : sum.saturated;
         rsp_ff.last_result  <= last_ff;
      end
   end

   hsa2d_bin_store #(
      .BIN_COUNT (BIN_COUNT),
      .ADDR_W    (ADDR_W),
      .DATA_W    (VALUE_W)
   ) u_bin_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while an item is still in flight");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_of_range |->
         rsp_data.bin_total == '0 && !rsp_data.saturated)
      else $error("dropped item returned a total or saturation flag");

   a_sat_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         rsp_data.bin_total == {1'b1, {(VALUE_W-1){1'b0}}} ||
         rsp_data.bin_total == {1'b0, {(VALUE_W-1){1'b1}}})
      else $error("saturated total not at a range limit");

endmodule
`default_nettype wire
